// File: hw/rtl/aes_gcm_authenticated_cipher_defines.svh
// Assertion macros used by the checker file of the GCM engine.
`ifndef AES_GCM_AUTHENTICATED_CIPHER_DEFINES_SVH
`define AES_GCM_AUTHENTICATED_CIPHER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GCM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gcm check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GCM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gcm check failed");

`endif

// File: hw/rtl/gcm_pkg.sv
// Types, codes and the S-box table of the GCM engine.
package gcm_pkg;

  localparam logic [1:0] KIND_AAD    = 2'd0;
  localparam logic [1:0] KIND_TEXT   = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;
  localparam logic [1:0] KIND_RSV    = 2'd3;

  localparam logic [2:0] CFG_KEY0    = 3'd0;
  localparam logic [2:0] CFG_KEY1    = 3'd1;
  localparam logic [2:0] CFG_KEY2    = 3'd2;
  localparam logic [2:0] CFG_KEY3    = 3'd3;
  localparam logic [2:0] CFG_KEY256  = 3'd4;
  localparam logic [2:0] CFG_NONCE_H = 3'd5;
  localparam logic [2:0] CFG_NONCE_L = 3'd6;
  localparam logic [2:0] CFG_DECRYPT = 3'd7;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic [4:0]  byte_count;
  } gcm_in_t;

  typedef struct packed {
    logic        out_kind;
    logic [63:0] out_high;
    logic [63:0] out_low;
    logic        tag_ok;
    logic        order_error;
  } gcm_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } gcm_unit_stat_t;

  typedef struct packed {
    logic expand;
    logic encrypt;
  } gcm_aes_req_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EXP_GO, ST_EXP_WAIT, ST_H_GO, ST_H_WAIT, ST_J0_GO, ST_J0_WAIT,
    ST_DISPATCH, ST_CTR_GO, ST_CTR_WAIT, ST_GH_GO, ST_GH_WAIT, ST_RESULT
  } gcm_state_e;

  typedef enum logic [1:0] {
    AES_IDLE, AES_EXPAND, AES_ADD0, AES_ROUND
  } gcm_aes_state_e;

  typedef enum logic [1:0] {
    PH_IDLE, PH_AAD, PH_TEXT
  } gcm_phase_e;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

endpackage

// File: hw/rtl/gcm_ghash_unit.sv
// GHASH multiplier in GF(2^128), four bits of the operand per cycle.
module gcm_ghash_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [127:0]            x_i,
  input  logic [127:0]            h_i,
  output gcm_pkg::gcm_unit_stat_t stat_o,
  output logic [127:0]            z_o
);
  import gcm_pkg::*;

  logic         busy_q, done_q;
  logic [4:0]   cnt_q;
  logic [127:0] z_q, v_q, x_q;
  logic [127:0] z_d, v_d, x_d;

  // Four dependent shift-and-add steps of the bit-serial product.
  always_comb begin
    logic c;
    z_d = z_q;
    v_d = v_q;
    x_d = x_q;
    for (int k = 0; k < 4; k++) begin
      if (x_d[127]) z_d = z_d ^ v_d;
      c   = v_d[0];
      v_d = v_d >> 1;
      if (c) v_d[127:120] = v_d[127:120] ^ 8'he1;
      x_d = x_d << 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 5'd31);
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      z_q <= '0;
      v_q <= h_i;
      x_q <= x_i;
    end else if (busy_q) begin
      z_q <= z_d;
      v_q <= v_d;
      x_q <= x_d;
    end
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign z_o    = z_q;

endmodule

// File: hw/rtl/gcm_aes_unit.sv
// AES-128/256 key expansion and one-round-per-cycle block encryption.
module gcm_aes_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  gcm_pkg::gcm_aes_req_t   req_i,
  input  logic [255:0]            key_i,
  input  logic                    key_is_256_i,
  input  logic [127:0]            block_i,
  output gcm_pkg::gcm_unit_stat_t stat_o,
  output logic [127:0]            block_o
);
  import gcm_pkg::*;

  gcm_aes_state_e state_q, state_d;
  logic           nk8_q, done_q;
  logic [3:0]     nr_q, rnd_q;
  logic [5:0]     wi_q;
  logic [7:0]     rcon_q;
  logic [31:0]    win_q [8];
  logic [127:0]   st_q, rk_q;
  logic [127:0]   rk_mem [15];

  logic [3:0]     rd_addr, wr_addr;
  logic           wr_en;
  logic [127:0]   wr_data;
  logic [31:0]    nw;
  logic           rc_use;
  logic [5:0]     wi_last;

  function automatic logic [7:0] xt(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] subw(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
    logic [7:0]   b [16];
    logic [7:0]   t [16];
    logic [7:0]   a0, a1, a2, a3;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
    for (int i = 0; i < 16; i++) t[i] = SBOX[b[(i + 4*(i % 4)) % 16]];
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      if (last) begin
        r[127-32*c -: 32] = {a0, a1, a2, a3};
      end else begin
        r[127-32*c -: 32] = {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
                             a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
                             a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
                             xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
      end
    end
    return r;
  endfunction

  // One new key word per cycle from the sliding window of the last eight.
  always_comb begin
    logic [31:0] t;
    t      = win_q[0];
    rc_use = nk8_q ? (wi_q[2:0] == 3'd0) : (wi_q[1:0] == 2'd0);
    if (rc_use) begin
      t = subw({t[23:0], t[31:24]}) ^ {rcon_q, 24'd0};
    end else if (nk8_q && wi_q[2:0] == 3'd4) begin
      t = subw(t);
    end
    nw = (nk8_q ? win_q[7] : win_q[3]) ^ t;
  end

  assign wi_last = nk8_q ? 6'd59 : 6'd43;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      AES_IDLE: begin
        if (req_i.expand) state_d = AES_EXPAND;
        else if (req_i.encrypt) state_d = AES_ADD0;
      end
      AES_EXPAND: if (wi_q == wi_last) state_d = AES_IDLE;
      AES_ADD0:   state_d = AES_ROUND;
      AES_ROUND:  if (rnd_q == nr_q) state_d = AES_IDLE;
      default:    state_d = AES_IDLE;
    endcase
  end

  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = key_i[255:128];
    unique case (state_q)
      AES_IDLE: wr_en = req_i.expand;
      AES_EXPAND: begin
        if (nk8_q && wi_q == 6'd8) begin
          wr_en   = 1'b1;
          wr_addr = 4'd1;
          wr_data = key_i[127:0];
        end else if (wi_q[1:0] == 2'd3) begin
          wr_en   = 1'b1;
          wr_addr = wi_q[5:2];
          wr_data = {win_q[2], win_q[1], win_q[0], nw};
        end
      end
      AES_ADD0:  rd_addr = 4'd1;
      AES_ROUND: rd_addr = (rnd_q == nr_q) ? 4'd0 : rnd_q + 4'd1;
      default:   rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) rk_mem[wr_addr] <= wr_data;
    rk_q <= rk_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AES_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == AES_EXPAND && wi_q == wi_last) ||
                 (state_q == AES_ROUND && rnd_q == nr_q);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      AES_IDLE: begin
        if (req_i.expand) begin
          nk8_q  <= key_is_256_i;
          nr_q   <= key_is_256_i ? 4'd14 : 4'd10;
          wi_q   <= key_is_256_i ? 6'd8 : 6'd4;
          rcon_q <= 8'h01;
          // A 128-bit key fills the lower four window slots; the upper four are unused.
          for (int j = 0; j < 8; j++) begin
            win_q[j] <= key_is_256_i ? key_i[32*j +: 32] : key_i[128+32*(j & 3) +: 32];
          end
        end else if (req_i.encrypt) begin
          st_q <= block_i;
        end
      end
      AES_EXPAND: begin
        wi_q     <= wi_q + 6'd1;
        win_q[0] <= nw;
        for (int j = 1; j < 8; j++) win_q[j] <= win_q[j-1];
        if (rc_use) rcon_q <= xt(rcon_q);
      end
      AES_ADD0: begin
        st_q  <= st_q ^ rk_q;
        rnd_q <= 4'd1;
      end
      AES_ROUND: begin
        st_q  <= aes_round(st_q, rnd_q == nr_q) ^ rk_q;
        rnd_q <= rnd_q + 4'd1;
      end
      default: ;
    endcase
  end

  assign stat_o  = '{busy: state_q != AES_IDLE, done: done_q};
  assign block_o = st_q;

endmodule

// File: hw/rtl/aes_gcm_authenticated_cipher.sv
// Top level of the AES-GCM engine: configuration, message sequencer, result register.
//
// AES-GCM with a 96-bit IV and an AES-128 or AES-256 key. One item is taken at
// a time; in_ready_o is low while it is worked on. An AES block is encrypted
// one round per cycle, with round keys read from a 15-row memory, and a GHASH
// multiply handles four bits per cycle. The first item of each message first
// expands the key and encrypts the zero block and J0. Key and key size are taken
// when a message starts; the nonce and decrypt mode are read as they stand when
// each item is worked on. Decrypted text is released before the tag is checked.
// The result register holds one finished item, so the next input item is taken
// while it waits. An item with the unused kind code is dropped without effect.
module aes_gcm_authenticated_cipher (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  gcm_pkg::gcm_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output gcm_pkg::gcm_out_t out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [2:0]       cfg_index_i,
  input  logic [63:0]      cfg_data_i
);
  import gcm_pkg::*;

  // Configuration registers.
  logic [3:0][63:0] key_q;
  logic             key256_q, decrypt_q;
  logic [63:0]      nonce_h_q;
  logic [31:0]      nonce_l_q;

  // Message state.
  gcm_state_e   state_q, state_d;
  gcm_phase_e   phase_q;
  gcm_in_t      item_q;
  logic [127:0] acc_q, h_q, mask_q, gh_data_q;
  logic [31:0]  ctr_q;
  logic [63:0]  aad_q, txt_q;
  gcm_out_t     res_q, out_q;
  logic         out_valid_q;

  // Unit handshakes.
  gcm_aes_req_t   aes_req;
  gcm_unit_stat_t aes_stat, gh_stat;
  logic [127:0]   aes_in, aes_out, gh_z;
  logic           gh_start;

  // Item decode: byte count clamped to sixteen and the matching byte mask.
  logic [4:0]   n_c;
  logic [127:0] msk, blk, ks_text;
  logic [63:0]  bits8;
  logic         out_free;

  assign n_c      = (item_q.byte_count > 5'd16) ? 5'd16 : item_q.byte_count;
  assign msk      = {128{1'b1}} << (8'd128 - {n_c, 3'b000});
  assign blk      = {item_q.block_high, item_q.block_low} & msk;
  assign bits8    = {56'd0, n_c, 3'b000};
  assign ks_text  = (blk ^ aes_out) & msk;
  assign out_free = !out_valid_q || out_ready_i;

  gcm_aes_unit u_aes (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (aes_req),
    .key_i        ({key_q[0], key_q[1], key_q[2], key_q[3]}),
    .key_is_256_i (key256_q),
    .block_i      (aes_in),
    .stat_o       (aes_stat),
    .block_o      (aes_out)
  );

  gcm_ghash_unit u_ghash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gh_start),
    .x_i     (acc_q ^ gh_data_q),
    .h_i     (h_q),
    .stat_o  (gh_stat),
    .z_o     (gh_z)
  );

  // Next-state logic of the message sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_data_i.kind != KIND_RSV) begin
          state_d = (phase_q == PH_IDLE) ? ST_EXP_GO : ST_DISPATCH;
        end
      end
      ST_EXP_GO:   state_d = ST_EXP_WAIT;
      ST_EXP_WAIT: if (aes_stat.done) state_d = ST_H_GO;
      ST_H_GO:     state_d = ST_H_WAIT;
      ST_H_WAIT:   if (aes_stat.done) state_d = ST_J0_GO;
      ST_J0_GO:    state_d = ST_J0_WAIT;
      ST_J0_WAIT:  if (aes_stat.done) state_d = ST_DISPATCH;
      ST_DISPATCH: begin
        case (item_q.kind)
          KIND_AAD: begin
            if (phase_q == PH_TEXT) state_d = ST_RESULT;
            else if (n_c == 5'd0)   state_d = ST_IDLE;
            else                    state_d = ST_GH_GO;
          end
          KIND_TEXT: state_d = (n_c == 5'd0) ? ST_RESULT : ST_CTR_GO;
          default:   state_d = ST_GH_GO;
        endcase
      end
      ST_CTR_GO:   state_d = ST_CTR_WAIT;
      ST_CTR_WAIT: if (aes_stat.done) state_d = ST_GH_GO;
      ST_GH_GO:    state_d = ST_GH_WAIT;
      ST_GH_WAIT: begin
        if (gh_stat.done) state_d = (item_q.kind == KIND_AAD) ? ST_IDLE : ST_RESULT;
      end
      ST_RESULT:   if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: unit launches and the input handshake.
  always_comb begin
    in_ready_o     = 1'b0;
    aes_req        = '{expand: 1'b0, encrypt: 1'b0};
    aes_in         = {nonce_h_q, nonce_l_q, ctr_q};
    gh_start       = 1'b0;
    unique case (state_q)
      ST_IDLE:   in_ready_o = 1'b1;
      ST_EXP_GO: aes_req.expand = 1'b1;
      ST_H_GO: begin
        aes_req.encrypt = 1'b1;
        aes_in          = '0;
      end
      ST_J0_GO: begin
        aes_req.encrypt = 1'b1;
        aes_in          = {nonce_h_q, nonce_l_q, 32'd1};
      end
      ST_CTR_GO: aes_req.encrypt = 1'b1;
      ST_GH_GO:  gh_start = 1'b1;
      default:   ;
    endcase
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q     <= '0;
      key256_q  <= 1'b0;
      nonce_h_q <= '0;
      nonce_l_q <= '0;
      decrypt_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_KEY0:    key_q[0]  <= cfg_data_i;
        CFG_KEY1:    key_q[1]  <= cfg_data_i;
        CFG_KEY2:    key_q[2]  <= cfg_data_i;
        CFG_KEY3:    key_q[3]  <= cfg_data_i;
        CFG_KEY256:  key256_q  <= cfg_data_i[0];
        CFG_NONCE_H: nonce_h_q <= cfg_data_i;
        CFG_NONCE_L: nonce_l_q <= cfg_data_i[31:0];
        CFG_DECRYPT: decrypt_q <= cfg_data_i[0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_IDLE;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      ctr_q       <= 32'd2;
      aad_q       <= '0;
      txt_q       <= '0;
    end else begin
      state_q     <= state_d;
      // A new result is loaded when the register is empty or the old one leaves; otherwise it is held.
      out_valid_q <= (state_q == ST_RESULT && out_free) || (out_valid_q && !out_ready_i);
      unique case (state_q)
        ST_J0_WAIT: begin
          if (aes_stat.done) begin
            acc_q   <= '0;
            ctr_q   <= 32'd2;
            aad_q   <= '0;
            txt_q   <= '0;
            phase_q <= PH_AAD;
          end
        end
        ST_DISPATCH: begin
          if (item_q.kind == KIND_AAD && phase_q != PH_TEXT && n_c != 5'd0) begin
            aad_q <= aad_q + bits8;
          end
          if (item_q.kind == KIND_TEXT) phase_q <= PH_TEXT;
        end
        ST_CTR_WAIT: begin
          if (aes_stat.done) begin
            ctr_q <= ctr_q + 32'd1;
            txt_q <= txt_q + bits8;
          end
        end
        ST_GH_WAIT: begin
          if (gh_stat.done) begin
            if (item_q.kind == KIND_FINISH) begin
              // The message ends here: back to the state after reset.
              acc_q   <= '0;
              ctr_q   <= 32'd2;
              aad_q   <= '0;
              txt_q   <= '0;
              phase_q <= PH_IDLE;
            end else begin
              acc_q <= gh_z;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: if (in_valid_i) item_q <= in_data_i;
      ST_H_WAIT:  if (aes_stat.done) h_q <= aes_out;
      ST_J0_WAIT: if (aes_stat.done) mask_q <= aes_out;
      ST_DISPATCH: begin
        // Only an AAD item that reaches the result state is an order error.
        res_q <= '{out_kind: 1'b0, out_high: '0, out_low: '0, tag_ok: 1'b0,
                   order_error: (item_q.kind == KIND_AAD)};
        case (item_q.kind)
          KIND_AAD:    gh_data_q <= blk;
          KIND_FINISH: gh_data_q <= {aad_q, txt_q};
          default: ;
        endcase
      end
      ST_CTR_WAIT: begin
        if (aes_stat.done) begin
          res_q.out_high <= ks_text[127:64];
          res_q.out_low  <= ks_text[63:0];
          gh_data_q      <= decrypt_q ? blk : ks_text;
        end
      end
      ST_GH_WAIT: begin
        if (gh_stat.done && item_q.kind == KIND_FINISH) begin
          res_q.out_kind <= 1'b1;
          res_q.out_high <= gh_z[127:64] ^ mask_q[127:64];
          res_q.out_low  <= gh_z[63:0] ^ mask_q[63:0];
          res_q.tag_ok   <= decrypt_q &&
                            ((gh_z ^ mask_q) == {item_q.block_high, item_q.block_low});
        end
      end
      ST_RESULT: if (out_free) out_q <= res_q;
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: hw/rtl/gcm_checker.sv
// Port-level checks of the GCM engine and their attachment to the top level.
`include "aes_gcm_authenticated_cipher_defines.svh"

module gcm_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input gcm_pkg::gcm_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input gcm_pkg::gcm_out_t out_data_o
);
  import gcm_pkg::*;

  `GCM_ASSERT_NXT(a_busy_after_item, clk_i, rst_ni,
                  in_valid_i && in_ready_o && in_data_i.kind != KIND_RSV, !in_ready_o)
  `GCM_ASSERT_NXT(a_out_held, clk_i, rst_ni, out_valid_o && !out_ready_i,
                  out_valid_o && $stable(out_data_o))
  `GCM_ASSERT_IMP(a_tag_ok_on_tag, clk_i, rst_ni, out_valid_o && out_data_o.tag_ok,
                  out_data_o.out_kind)
  `GCM_ASSERT_IMP(a_err_on_text, clk_i, rst_ni, out_valid_o && out_data_o.order_error,
                  !out_data_o.out_kind && out_data_o.out_high == 64'd0 &&
                  out_data_o.out_low == 64'd0)

endmodule

bind aes_gcm_authenticated_cipher gcm_checker u_gcm_checker (.*);

// File: test/aes_gcm_authenticated_cipher_tb.sv
// Self-checking testbench of the AES-GCM engine, with its own cipher and GHASH predictor.
//
// The testbench models the engine in plain behavioral code. It builds its own S-box
// from the field inverse, expands the key, runs the AES rounds and GHASH, and keeps
// its own copy of the message state. Every accepted input item other than the unused
// kind updates that model. Every item that returns something queues the expected result.
// A checker process compares each accepted result field by field against the oldest queued one.
//
// Registers are written only between messages, after every queued result has arrived
// and the engine has had time to settle. This makes key and nonce latching moot.
module aes_gcm_authenticated_cipher_tb;
  import gcm_pkg::*;

  logic              clk;
  logic              rst_ni;
  logic              in_valid;
  logic              in_ready;
  gcm_in_t           in_data;
  logic              out_valid;
  logic              out_ready;
  gcm_out_t          out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [2:0]        cfg_index;
  logic [63:0]       cfg_data;

  aes_gcm_authenticated_cipher DUT (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Mirror of the configuration registers.
  logic [63:0] key_words [4];
  logic        key_256;
  logic [63:0] iv_high;
  logic [31:0] iv_low;
  logic        decrypting;

  // Model of the message state.
  logic [7:0]   sbox_tab [256];
  logic [31:0]  key_sched [60];
  int           round_count;
  logic [127:0] hash_key;
  logic [127:0] j0_mask;
  logic [127:0] ghash_acc;
  logic [31:0]  ctr;
  logic [63:0]  aad_len_bits;
  logic [63:0]  text_bits;
  gcm_phase_e   phase;

  gcm_out_t    pending_results [$];
  int          mismatches;
  int          items_sent;
  logic        quiet;        // When set, neither side inserts gaps.
  int          stall_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run, far above the slowest correct run.
  initial begin
    #40000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [7:0] xtime(logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf8_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = xtime(a);
    end
    return p;
  endfunction

  // The S-box is the field inverse followed by the affine map.
  task automatic build_sbox();
    logic [7:0] inv;
    logic [7:0] s;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h01;
      for (int k = 0; k < 254; k++) inv = gf8_mul(inv, x[7:0]);
      if (x == 0) inv = 8'h00;
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sbox_tab[x] = s;
    end
  endtask

  function automatic logic [31:0] sbox_word(logic [31:0] w);
    return {sbox_tab[w[31:24]], sbox_tab[w[23:16]], sbox_tab[w[15:8]], sbox_tab[w[7:0]]};
  endfunction

  task automatic expand_key_sched();
    int         nk;
    logic [31:0] t;
    logic [7:0] rcon;
    nk = key_256 ? 8 : 4;
    round_count = key_256 ? 14 : 10;
    for (int i = 0; i < nk; i++)
      key_sched[i] = (i % 2) ? key_words[i / 2][31:0] : key_words[i / 2][63:32];
    rcon = 8'h01;
    for (int i = nk; i < 4 * (round_count + 1); i++) begin
      t = key_sched[i - 1];
      if (i % nk == 0) begin
        t = sbox_word({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
        rcon = xtime(rcon);
      end else if (nk == 8 && i % 8 == 4) begin
        t = sbox_word(t);
      end
      key_sched[i] = key_sched[i - nk] ^ t;
    end
  endtask

  function automatic logic [127:0] aes_encrypt(logic [127:0] blk);
    logic [7:0]  s [16];
    logic [7:0]  t [16];
    logic [31:0] k;
    logic [7:0]  a, b, c, d;
    logic [127:0] res;
    for (int i = 0; i < 16; i++) s[i] = blk[127 - 8 * i -: 8];
    for (int r = 0; r <= round_count; r++) begin
      if (r > 0) begin
        for (int i = 0; i < 16; i++) t[i] = sbox_tab[s[(i + 4 * (i % 4)) % 16]];
        for (int col = 0; col < 4; col++) begin
          a = t[4 * col]; b = t[4 * col + 1]; c = t[4 * col + 2]; d = t[4 * col + 3];
          if (r < round_count) begin
            s[4 * col]     = xtime(a) ^ xtime(b) ^ b ^ c ^ d;
            s[4 * col + 1] = a ^ xtime(b) ^ xtime(c) ^ c ^ d;
            s[4 * col + 2] = a ^ b ^ xtime(c) ^ xtime(d) ^ d;
            s[4 * col + 3] = xtime(a) ^ a ^ b ^ c ^ xtime(d);
          end else begin
            s[4 * col] = a; s[4 * col + 1] = b; s[4 * col + 2] = c; s[4 * col + 3] = d;
          end
        end
      end
      for (int col = 0; col < 4; col++) begin
        k = key_sched[r * 4 + col];
        for (int j = 0; j < 4; j++) s[4 * col + j] ^= k[31 - 8 * j -: 8];
      end
    end
    for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = s[i];
    return res;
  endfunction

  // GHASH multiply, bit-reflected as the GCM spec defines it.
  function automatic logic [127:0] gf128_mul(logic [127:0] x, logic [127:0] h);
    logic [127:0] z;
    logic [127:0] v;
    logic         carry;
    z = '0;
    v = h;
    for (int i = 0; i < 128; i++) begin
      if (x[127 - i]) z ^= v;
      carry = v[0];
      v = v >> 1;
      if (carry) v[127:120] ^= 8'he1;
    end
    return z;
  endfunction

  function automatic logic [127:0] counter_block(logic [31:0] c);
    return {iv_high, iv_low, c};
  endfunction

  task automatic clear_message_state();
    ghash_acc = '0;
    ctr = 32'd2;
    aad_len_bits = '0;
    text_bits = '0;
    phase = PH_IDLE;
  endtask

  // Tag that a finish item would produce now, used to send a matching tag.
  function automatic logic [127:0] current_tag();
    return gf128_mul(ghash_acc ^ {aad_len_bits, text_bits}, hash_key) ^ j0_mask;
  endfunction

  // Advances the model by one accepted item and queues its result, if any.
  task automatic model_item(gcm_in_t it);
    int           n;
    logic [127:0] mask;
    logic [127:0] blk;
    logic [127:0] res;
    gcm_out_t     r;
    if (it.kind == KIND_RSV) return;
    n = (it.byte_count > 16) ? 16 : int'(it.byte_count);
    mask = (n == 0) ? '0 : ({128{1'b1}} << (8 * (16 - n)));
    blk = {it.block_high, it.block_low} & mask;
    if (phase == PH_IDLE) begin
      expand_key_sched();
      hash_key = aes_encrypt('0);
      j0_mask = aes_encrypt(counter_block(32'd1));
      clear_message_state();
      phase = PH_AAD;
    end
    r = '0;
    case (it.kind)
      KIND_AAD: begin
        if (phase == PH_TEXT) begin
          r.order_error = 1'b1;
          pending_results.push_back(r);
        end else if (n != 0) begin
          ghash_acc = gf128_mul(ghash_acc ^ blk, hash_key);
          aad_len_bits += 64'(8 * n);
        end
      end
      KIND_TEXT: begin
        phase = PH_TEXT;
        if (n != 0) begin
          res = (blk ^ aes_encrypt(counter_block(ctr))) & mask;
          ctr = ctr + 32'd1;
          ghash_acc = gf128_mul(ghash_acc ^ (decrypting ? blk : res), hash_key);
          text_bits += 64'(8 * n);
          {r.out_high, r.out_low} = res;
        end
        pending_results.push_back(r);
      end
      default: begin
        res = current_tag();
        r.out_kind = 1'b1;
        {r.out_high, r.out_low} = res;
        r.tag_ok = decrypting && (res == {it.block_high, it.block_low});
        pending_results.push_back(r);
        clear_message_state();
      end
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // Sends one item; returns at the edge at which it was accepted.
  task automatic send_item(gcm_in_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    model_item(it);
    items_sent++;
  endtask

  function automatic gcm_in_t make_item(logic [1:0] kind, logic [4:0] count);
    gcm_in_t it;
    it.kind = kind;
    it.block_high = {$urandom, $urandom};
    it.block_low = {$urandom, $urandom};
    it.byte_count = count;
    return it;
  endfunction

  // Finish item; in decrypt mode the tag matches when asked to and the message has started.
  task automatic send_finish(logic good_tag);
    gcm_in_t it;
    it = make_item(KIND_FINISH, 5'($urandom_range(31)));
    if (good_tag && phase != PH_IDLE) {it.block_high, it.block_low} = current_tag();
    send_item(it);
  endtask

  // Waits until the engine has returned everything and gone quiet.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // Holds a register write until it is taken; the caller drops the valid.
  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_KEY0, CFG_KEY1, CFG_KEY2, CFG_KEY3: key_words[idx[1:0]] = value;
      CFG_KEY256:  key_256 = value[0];
      CFG_NONCE_H: iv_high = value;
      CFG_NONCE_L: iv_low = value[31:0];
      default:     decrypting = value[0];
    endcase
  endtask

  task automatic configure(logic [255:0] key, logic wide, logic [95:0] iv, logic dec);
    drain();
    write_reg(CFG_KEY0, key[255:192]);
    write_reg(CFG_KEY1, key[191:128]);
    write_reg(CFG_KEY2, key[127:64]);
    write_reg(CFG_KEY3, key[63:0]);
    write_reg(CFG_KEY256, {63'h0, wide});
    write_reg(CFG_NONCE_H, iv[95:32]);
    write_reg(CFG_NONCE_L, {32'h0, iv[31:0]});
    write_reg(CFG_DECRYPT, {63'h0, dec});
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [255:0] random_key();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  // Encrypt with AES-128, covering each byte-count corner, an AAD item that
  // arrives after text, and the unused kind code.
  task automatic test_encrypt_corners();
    configure('0, 1'b0, '0, 1'b0);
    send_item(make_item(KIND_AAD, 5'd16));
    send_item(make_item(KIND_AAD, 5'd0));
    send_item(make_item(KIND_AAD, 5'd5));
    send_item(make_item(KIND_RSV, 5'd16));
    send_item(make_item(KIND_AAD, 5'd31));
    send_item(make_item(KIND_TEXT, 5'd16));
    send_item(make_item(KIND_TEXT, 5'd0));
    send_item(make_item(KIND_TEXT, 5'd8));
    send_item(make_item(KIND_AAD, 5'd16));
    send_item(make_item(KIND_TEXT, 5'd20));
    send_item(make_item(KIND_TEXT, 5'd1));
    send_finish(1'b0);
    // A message that is only a finish item, and one that starts with text.
    send_finish(1'b0);
    send_item(make_item(KIND_TEXT, 5'd15));
    send_finish(1'b0);
  endtask

  // Decrypt with AES-256 and all-ones settings, with good and bad tags.
  task automatic test_decrypt_tags();
    configure({256{1'b1}}, 1'b1, {96{1'b1}}, 1'b1);
    send_item(make_item(KIND_AAD, 5'd9));
    send_item(make_item(KIND_TEXT, 5'd16));
    send_item(make_item(KIND_TEXT, 5'd7));
    send_finish(1'b1);
    send_item(make_item(KIND_TEXT, 5'd16));
    send_finish(1'b0);
    send_item(make_item(KIND_AAD, 5'd16));
    send_finish(1'b1);
  endtask

  // Random messages: mostly well formed, some with odd counts and stray items.
  task automatic test_random_messages();
    int  n_aad;
    int  n_text;
    int  msg;
    logic [4:0] cnt;
    msg = 0;
    while (items_sent < 850) begin
      if (msg % 8 == 0)
        configure(random_key(), 1'($urandom_range(1)), {$urandom, $urandom, $urandom},
                  1'($urandom_range(1)));
      quiet = ($urandom_range(9) == 0);
      n_aad = $urandom_range(3);
      n_text = $urandom_range(4);
      for (int i = 0; i < n_aad; i++) begin
        cnt = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'd16;
        send_item(make_item(KIND_AAD, cnt));
      end
      for (int i = 0; i < n_text; i++) begin
        cnt = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'd16;
        send_item(make_item(KIND_TEXT, cnt));
        if ($urandom_range(19) == 0) send_item(make_item(KIND_AAD, 5'($urandom_range(31))));
        if ($urandom_range(29) == 0) send_item(make_item(KIND_RSV, 5'($urandom_range(31))));
      end
      send_finish(1'($urandom_range(1)));
      msg++;
    end
    quiet = 1'b0;
  endtask

  // Result-side stalls: mostly short, a few long, none while quiet.
  always @(posedge clk or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!quiet && $urandom_range(3) == 0)
        stall_left <= ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    gcm_out_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result item: %p", out_data);
      end else begin
        want = pending_results.pop_front();
        if (want.out_kind !== out_data.out_kind || want.out_high !== out_data.out_high ||
            want.out_low !== out_data.out_low || want.tag_ok !== out_data.tag_ok ||
            want.order_error !== out_data.order_error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
  end

  initial begin
    rst_ni <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_KEY0;
    cfg_data <= '0;
    mismatches = 0;
    items_sent = 0;
    quiet = 1'b0;
    for (int i = 0; i < 4; i++) key_words[i] = '0;
    key_256 = 1'b0;
    iv_high = '0;
    iv_low = '0;
    decrypting = 1'b0;
    round_count = 10;
    build_sbox();
    clear_message_state();
    repeat (10) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_encrypt_corners();
    test_decrypt_tags();
    test_random_messages();

    drain();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/gcm_pkg.sv
hw/rtl/gcm_ghash_unit.sv
hw/rtl/gcm_aes_unit.sv
hw/rtl/aes_gcm_authenticated_cipher.sv
hw/rtl/gcm_checker.sv
test/aes_gcm_authenticated_cipher_tb.sv
